/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by nsfc_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset
`define NSFC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included
`define NSFC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/nsfc_pkg.sv */
// ----------------------------------------------------------------------------
// nsfc_pkg
// Types, character codes and header tables for the NMEA sentence filter.
// ----------------------------------------------------------------------------
package nsfc_pkg;

  // Default sentence length limit, '$' included
  localparam int MAX_LEN_DEF = 128;

  // Sentence types reported in a result
  typedef enum logic [1:0] {
    SENT_NONE  = 2'd0,
    SENT_GNRMC = 2'd1,
    SENT_GPGSA = 2'd2,
    SENT_GNGGA = 2'd3
  } sent_type_t;

  // Characters with a control meaning
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam int HDR_COUNT = 3;
  localparam int HDR_CHARS = 5;

  // Accepted talker/sentence headers, in type order
  localparam logic [7:0] HDR_NAMES [HDR_COUNT][HDR_CHARS] = '{
    '{8'h47, 8'h4E, 8'h52, 8'h4D, 8'h43},  // GNRMC
    '{8'h47, 8'h50, 8'h47, 8'h53, 8'h41},  // GPGSA
    '{8'h47, 8'h4E, 8'h47, 8'h47, 8'h41}   // GNGGA
  };

  // One input beat as it sits in the input register
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } nsfc_beat_t;

  // One result beat
  typedef struct packed {
    sent_type_t sentence_type;
    logic       checksum_ok;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;
    logic       star_found;
  } nsfc_result_t;

  // Hex digit decode: bit 4 set means not a hex digit, low nibble then 0
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b0, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) v = {1'b0, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) v = {1'b0, 4'(c - 8'h57)};
    return v;
  endfunction

endpackage

/* rtl/nsfc_in_if.sv */
// ----------------------------------------------------------------------------
// nsfc_in_if
// Byte stream channel into the filter: valid, ready and the received byte.
// ----------------------------------------------------------------------------
interface nsfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

/* rtl/nsfc_out_if.sv */
// ----------------------------------------------------------------------------
// nsfc_out_if
// Result channel out of the filter: one beat per completed sentence.
// ----------------------------------------------------------------------------
interface nsfc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] sentence_type;
  logic       checksum_ok;
  logic [7:0] computed_sum;
  logic [7:0] received_sum;
  logic       star_found;

  modport source (output valid, output sentence_type, output checksum_ok,
                  output computed_sum, output received_sum, output star_found,
                  input ready);
  modport sink   (input valid, input sentence_type, input checksum_ok,
                  input computed_sum, input received_sum, input star_found,
                  output ready);
endinterface

/* rtl/nsfc_in_stage.sv */
// ----------------------------------------------------------------------------
// nsfc_in_stage
// Input register: holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
module nsfc_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  nsfc_in_if.sink             in_ch,
  input  logic                take,
  output nsfc_pkg::nsfc_beat_t beat
);
  import nsfc_pkg::*;

  logic       valid_r, valid_nxt;
  logic [7:0] data_r,  data_nxt;
  logic       load;

  // Free when empty or being consumed this cycle
  assign in_ch.ready = !valid_r || take;
  assign load        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = in_ch.rx_byte;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    data_r <= data_nxt;
  end

  assign beat.valid = valid_r;
  assign beat.data  = data_r;
endmodule

/* rtl/nsfc_parser.sv */
// ----------------------------------------------------------------------------
// nsfc_parser
// Sentence state: header match, length limit, XOR sum and checksum digits.
// ----------------------------------------------------------------------------
module nsfc_parser #(
  parameter int MAX_LEN = nsfc_pkg::MAX_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  logic [7:0]            rx_byte,
  output logic                  res_valid,
  output nsfc_pkg::nsfc_result_t res
);
  import nsfc_pkg::*;

  localparam int PosW = $clog2(MAX_LEN);

  typedef struct packed {
    logic                 in_sentence;
    logic [PosW-1:0]      char_position;
    logic [HDR_COUNT-1:0] header_match;
    sent_type_t           type_code;
    logic [7:0]           running_xor;
    logic                 star_seen;
    logic [1:0]           digits_taken;
    logic [7:0]           digit_value;
    logic                 digit_bad;
    logic                 text_ended;
  } parse_state_t;

  parse_state_t st_r, st_nxt, st_clear, st_rst;

  logic [2:0]           hdr_idx;
  logic                 in_hdr;
  logic [HDR_COUNT-1:0] hm_upd;
  logic [4:0]           hex_d;
  logic [7:0]           recv_sum;
  logic                 hit;

  // State as it stands right after a '$'
  always_comb begin
    st_clear               = '0;
    st_clear.in_sentence   = 1'b1;
    st_clear.char_position = PosW'(1);
    st_clear.header_match  = '1;
    st_clear.type_code     = SENT_NONE;
  end

  // State right after reset: idle, all headers still possible
  always_comb begin
    st_rst              = '0;
    st_rst.header_match = '1;
    st_rst.type_code    = SENT_NONE;
  end

  // Header compare against all candidates at the current position
  assign in_hdr  = (st_r.char_position >= PosW'(1)) && (st_r.char_position <= PosW'(5));
  assign hdr_idx = st_r.char_position[2:0] - 3'd1;

  always_comb begin
    hm_upd = st_r.header_match;
    if (in_hdr) begin
      for (int k = 0; k < HDR_COUNT; k++) begin
        if (HDR_NAMES[k][hdr_idx] != rx_byte) hm_upd[k] = 1'b0;
      end
    end
  end

  assign hex_d = hex_decode(rx_byte);

  // Received sum, missing digits count as zero
  always_comb begin
    case (st_r.digits_taken)
      2'd0:    recv_sum = 8'h00;
      2'd1:    recv_sum = {st_r.digit_value[3:0], 4'h0};
      default: recv_sum = st_r.digit_value;
    endcase
    if (!st_r.star_seen) recv_sum = 8'h00;
  end

  // Next state for the byte being consumed
  always_comb begin
    st_nxt = st_r;
    hit    = 1'b0;
    if (fire) begin
      if (rx_byte == CH_DOLLAR) begin
        st_nxt = st_clear;
      end else if (st_r.in_sentence) begin
        st_nxt.header_match = hm_upd;
        if (in_hdr && st_r.char_position == PosW'(5) && hm_upd == '0) begin
          // Unknown header
          st_nxt.in_sentence = 1'b0;
        end else if (st_r.char_position >= PosW'(MAX_LEN - 1)) begin
          // Overlong sentence
          st_nxt.in_sentence = 1'b0;
        end else begin
          if (in_hdr && st_r.char_position == PosW'(5)) begin
            if (hm_upd[0])      st_nxt.type_code = SENT_GNRMC;
            else if (hm_upd[1]) st_nxt.type_code = SENT_GPGSA;
            else                st_nxt.type_code = SENT_GNGGA;
          end
          if (rx_byte == CH_CR) begin
            hit                = 1'b1;
            st_nxt.in_sentence = 1'b0;
          end else begin
            if (!st_r.text_ended) begin
              if (rx_byte == CH_NUL) begin
                st_nxt.text_ended = 1'b1;
              end else if (!st_r.star_seen) begin
                if (rx_byte == CH_STAR) st_nxt.star_seen = 1'b1;
                else st_nxt.running_xor = st_r.running_xor ^ rx_byte;
              end else if (st_r.digits_taken != 2'd2) begin
                if (hex_d[4]) st_nxt.digit_bad = 1'b1;
                st_nxt.digit_value  = {st_r.digit_value[3:0], hex_d[3:0]};
                st_nxt.digits_taken = st_r.digits_taken + 2'd1;
              end
            end
            st_nxt.char_position = st_r.char_position + PosW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= st_rst;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Result fields come from the state before the carriage return
  assign res_valid          = hit;
  assign res.sentence_type  = st_r.type_code;
  assign res.computed_sum   = st_r.running_xor;
  assign res.received_sum   = recv_sum;
  assign res.star_found     = st_r.star_seen;
  assign res.checksum_ok    = st_r.star_seen && (st_r.digits_taken == 2'd2) &&
                              !st_r.digit_bad && (recv_sum == st_r.running_xor);
endmodule

/* rtl/nsfc_out_stage.sv */
// ----------------------------------------------------------------------------
// nsfc_out_stage
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module nsfc_out_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  res_valid,
  input  nsfc_pkg::nsfc_result_t res,
  output logic                  free,
  nsfc_out_if.source            out_ch
);
  import nsfc_pkg::*;

  logic         valid_r, valid_nxt;
  nsfc_result_t res_r,   res_nxt;

  // Room for a new result when empty or draining this cycle
  assign free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (res_valid) begin
      valid_nxt = 1'b1;
      res_nxt   = res;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    res_r <= res_nxt;
  end

  assign out_ch.valid         = valid_r;
  assign out_ch.sentence_type = res_r.sentence_type;
  assign out_ch.checksum_ok   = res_r.checksum_ok;
  assign out_ch.computed_sum  = res_r.computed_sum;
  assign out_ch.received_sum  = res_r.received_sum;
  assign out_ch.star_found    = res_r.star_found;
endmodule

/* rtl/nmea_sentence_filter_checksum.sv */
// ----------------------------------------------------------------------------
// nmea_sentence_filter_checksum
// NMEA 0183 sentence filter: keeps GNRMC, GPGSA and GNGGA sentences and
// checks their XOR checksum, one result per carriage return ending a sentence.
// ----------------------------------------------------------------------------
//  channel   direction  payload                                   beats
//  in_ch     in         rx_byte                                   one per byte
//  out_ch    out        sentence_type, checksum_ok, computed_sum,  one per
//                       received_sum, star_found                   sentence
//
// One byte per cycle sustained while the result register is free; a byte
// is held in the input register; its result, if any, is registered when taken.
// Reset is synchronous on rst_n and leaves both registers empty.
// A stalled result holds the parser; bytes back up into the input register.
// ----------------------------------------------------------------------------
module nmea_sentence_filter_checksum #(
  parameter int MAX_LEN = nsfc_pkg::MAX_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  nsfc_in_if.sink    in_ch,
  nsfc_out_if.source out_ch
);
  import nsfc_pkg::*;

  nsfc_beat_t   beat;
  nsfc_result_t res;
  logic         res_valid;
  logic         out_free;
  logic         fire;

  // Consume the held byte whenever the result register can take a result
  assign fire = beat.valid && out_free;

  nsfc_in_stage u_in (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .take  (fire),
    .beat  (beat)
  );

  nsfc_parser #(
    .MAX_LEN (MAX_LEN)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .rx_byte   (beat.data),
    .res_valid (res_valid),
    .res       (res)
  );

  nsfc_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .free      (out_free),
    .out_ch    (out_ch)
  );
endmodule

/* rtl/nsfc_checker.sv */
// ----------------------------------------------------------------------------
// nsfc_checker
// Port-level checks on the result channel of the sentence filter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nsfc_checker (
  input logic        clk,
  input logic        rst_n,
  nsfc_out_if.source out_ch
);

  // A shown result waits for the sink
  `NSFC_ASSERT(a_valid_hold, clk, rst_n, out_ch.valid && !out_ch.ready |=> out_ch.valid, "result beat dropped while stalled")

  // A stalled result keeps its sums
  `NSFC_ASSERT(a_sum_hold, clk, rst_n, out_ch.valid && !out_ch.ready |=> $stable(out_ch.computed_sum) && $stable(out_ch.received_sum), "result sums changed while stalled")

  // No star means no received digits and no match
  `NSFC_ASSERT(a_no_star, clk, rst_n, out_ch.valid && !out_ch.star_found |-> out_ch.received_sum == 8'h00 && !out_ch.checksum_ok, "digits reported without a star")

  // A match needs equal sums
  `NSFC_ASSERT(a_ok_equal, clk, rst_n, out_ch.valid && out_ch.checksum_ok |-> out_ch.received_sum == out_ch.computed_sum, "checksum_ok with unequal sums")

  // Reset empties the result register
  `NSFC_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_ch.valid, "result valid right after reset")

endmodule

bind nmea_sentence_filter_checksum nsfc_checker u_nsfc_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .out_ch (out_ch)
);
